// File: hdl/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared types and constants of the cascaded biquad filter: sample and
// coefficient formats, tap codes and the controller to datapath command word.
// ----------------------------------------------------------------------------
package bqf_pkg;

   localparam int DataW          = 24;               // Q1.23 sample
   localparam int CoefW          = 26;               // Q4.22 coefficient
   localparam int ProdW          = DataW + CoefW;    // one full product
   localparam int AccW           = 53;               // sum of five products
   localparam int FracShift      = 22;               // coefficient fraction bits
   localparam int SatBit         = DataW - 1 + FracShift;
   localparam int TapsPerSection = 5;
   localparam int SecIdxW        = 2;
   localparam int SelW           = 3;

   localparam logic signed [CoefW-1:0] CoefOne   = CoefW'(4194304);
   localparam logic signed [AccW-1:0]  RoundHalf = AccW'(2097152);
   localparam logic signed [DataW-1:0] DataMax   = {1'b0, {(DataW-1){1'b1}}};
   localparam logic signed [DataW-1:0] DataMin   = {1'b1, {(DataW-1){1'b0}}};

   typedef enum logic {
      OP_FILTER = 1'b0,
      OP_COEF   = 1'b1
   } op_type;

   typedef enum logic [SelW-1:0] {
      TAP_B0 = 3'd0,
      TAP_B1 = 3'd1,
      TAP_B2 = 3'd2,
      TAP_A1 = 3'd3,
      TAP_A2 = 3'd4
   } tap_type;

   typedef struct packed {
      logic    coef_we;      // store one coefficient word
      logic    sample_load;  // take a new sample, clear the clip flag
      logic    mac_en;       // issue one product
      tap_type tap;          // which product is issued
      logic    hist_rd;      // read one history word
      logic    hist_cap;     // keep the history word read as x1
      logic    hist_we;      // write one history word
      logic    hist_wr_x1;   // write data is x1, else the section input
      logic    round;        // round and saturate the sum
      logic    out_load;     // move the result to the output register
   } dp_cmd_type;

endpackage

// File: hdl/cascaded_biquad_iir_filter.sv
// Cascaded biquad IIR filter, direct form I. A request with tuser 0 filters
// one Q1.23 sample through SECTIONS second-order sections and returns one
// response; a request with tuser 1 loads one Q4.22 coefficient and returns
// nothing. For each section the single multiply-accumulate unit issues the
// five products one after another, the history pair of the section is
// written while the products drain from the pipeline, and the sum is
// rounded; after the last section the final output is shifted into
// history. A new request is taken while the last
// response still waits in the output register. After reset all coefficients
// are pass-through (b0 = 1.0, others 0) and the history is zero.
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter
// Top level: stream ports, request field unpacking, controller and datapath.
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_filter #(
   parameter int SECTIONS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sample_in[23:0], section_index[25:24], coef_select[28:26],
   // coef_value[54:29], zero[55]
   input  logic [55:0] req_tdata,
   // operation[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // sample_out[23:0]
   output logic [23:0] rsp_tdata,
   // saturated[0]
   output logic [0:0]  rsp_tuser
);

   import bqf_pkg::*;

   localparam int CoefAW = $clog2(5 * SECTIONS);
   localparam int HistAW = $clog2(2 * SECTIONS + 2);

   dp_cmd_type              cmd;
   op_type                  req_op;
   logic [CoefAW-1:0]       coef_addr;
   logic [HistAW-1:0]       hist_raddr;
   logic [HistAW-1:0]       hist_waddr;
   logic                    out_busy;
   logic signed [DataW-1:0] rsp_sample;
   logic                    rsp_sat;

   assign req_op = op_type'(req_tuser[0]);

   bqf_ctrl #(
      .SECTIONS (SECTIONS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_op      (req_op),
      .req_section (req_tdata[25:24]),
      .req_select  (req_tdata[28:26]),
      .out_busy    (out_busy),
      .cmd         (cmd),
      .coef_addr   (coef_addr),
      .hist_raddr  (hist_raddr),
      .hist_waddr  (hist_waddr)
   );

   bqf_dp #(
      .SECTIONS (SECTIONS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .coef_addr  (coef_addr),
      .hist_raddr (hist_raddr),
      .hist_waddr (hist_waddr),
      .sample_in  (req_tdata[23:0]),
      .coef_value (req_tdata[54:29]),
      .rsp_tready (rsp_tready),
      .out_busy   (out_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_sample (rsp_sample),
      .rsp_sat    (rsp_sat)
   );

   assign rsp_tdata    = rsp_sample;
   assign rsp_tuser[0] = rsp_sat;

endmodule

// File: hdl/bqf_ram.sv
// ----------------------------------------------------------------------------
// bqf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bqf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bqf_dp.sv
// ----------------------------------------------------------------------------
// bqf_dp
// Datapath: coefficient and history memories, one shared multiply-accumulate
// unit, rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module bqf_dp #(
   parameter int SECTIONS = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bqf_pkg::dp_cmd_type                     cmd,
   input  logic [$clog2(5*SECTIONS)-1:0]           coef_addr,
   input  logic [$clog2(2*SECTIONS+2)-1:0]         hist_raddr,
   input  logic [$clog2(2*SECTIONS+2)-1:0]         hist_waddr,
   input  logic signed [bqf_pkg::DataW-1:0]        sample_in,
   input  logic signed [bqf_pkg::CoefW-1:0]        coef_value,
   input  logic                                    rsp_tready,
   output logic                                    out_busy,
   output logic                                    rsp_tvalid,
   output logic signed [bqf_pkg::DataW-1:0]        rsp_sample,
   output logic                                    rsp_sat
);

   import bqf_pkg::*;

   localparam int CoefDepth = 5 * SECTIONS;
   localparam int HistDepth = 2 * SECTIONS + 2;

   // memories and their valid bits
   logic [CoefW-1:0]        coef_rd;
   logic [DataW-1:0]        hist_rd;
   logic [DataW-1:0]        hist_wdata;
   logic [CoefDepth-1:0]    coef_vld_ff, coef_vld_in;
   logic [HistDepth-1:0]    hist_vld_ff, hist_vld_in;
   logic                    coef_rdv_ff;
   logic                    hist_rdv_ff;

   // multiply-accumulate pipeline
   logic                    s1_mac_ff;
   tap_type                 s1_tap_ff;
   logic                    s1_cap_ff;
   logic                    s2_mac_ff;
   logic                    s2_first_ff;
   logic                    s2_neg_ff;
   logic signed [CoefW-1:0] coef_op;
   logic signed [DataW-1:0] data_op;
   logic signed [DataW-1:0] hist_op;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic signed [AccW-1:0]  prod_ext;
   logic signed [AccW-1:0]  acc_ff, acc_in;

   // section state and rounding
   logic signed [DataW-1:0] xin_ff, xin_in;
   logic signed [DataW-1:0] x1_ff;
   logic                    clip_ff, clip_in;
   logic signed [AccW-1:0]  rnd;
   logic [AccW-SatBit-1:0]  rnd_hi;
   logic                    rnd_ok;
   logic signed [DataW-1:0] y_rnd;

   // output register
   logic                    out_vld_ff, out_vld_in;
   logic signed [DataW-1:0] out_sample_ff;
   logic                    out_sat_ff;

   assign hist_wdata = cmd.hist_wr_x1 ? x1_ff : xin_ff;

   bqf_ram #(
      .WIDTH (CoefW),
      .DEPTH (CoefDepth)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (cmd.coef_we),
      .wr_addr (coef_addr),
      .wr_data (coef_value),
      .rd_en   (cmd.mac_en),
      .rd_addr (coef_addr),
      .rd_data (coef_rd)
   );

   bqf_ram #(
      .WIDTH (DataW),
      .DEPTH (HistDepth)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_en   (cmd.hist_rd),
      .rd_addr (hist_raddr),
      .rd_data (hist_rd)
   );

   always_comb begin
      coef_vld_in = coef_vld_ff;
      hist_vld_in = hist_vld_ff;
      if (cmd.coef_we) begin
         coef_vld_in[coef_addr] = 1'b1;
      end
      if (cmd.hist_we) begin
         hist_vld_in[hist_waddr] = 1'b1;
      end
   end

   // Unwritten coefficients read as pass-through, unwritten history as zero.
   always_comb begin
      if (coef_rdv_ff) begin
         coef_op = coef_rd;
      end else if (s1_tap_ff == TAP_B0) begin
         coef_op = CoefOne;
      end else begin
         coef_op = '0;
      end
      hist_op = hist_rdv_ff ? hist_rd : '0;
      data_op = (s1_tap_ff == TAP_B0) ? xin_ff : hist_op;
      prod_in = coef_op * data_op;
   end

   assign prod_ext = {{(AccW-ProdW){prod_ff[ProdW-1]}}, prod_ff};

   always_comb begin
      acc_in = acc_ff;
      if (s2_mac_ff) begin
         priority if (s2_first_ff) begin
            acc_in = prod_ext;
         end else if (s2_neg_ff) begin
            acc_in = acc_ff - prod_ext;
         end else begin
            acc_in = acc_ff + prod_ext;
         end
      end
   end

   // Round half up, then clip to the sample range.
   always_comb begin
      rnd    = acc_ff + RoundHalf;
      rnd_hi = rnd[AccW-1:SatBit];
      rnd_ok = (rnd_hi == '0) || (rnd_hi == '1);
      if (rnd_ok) begin
         y_rnd = rnd[SatBit:FracShift];
      end else if (rnd[AccW-1]) begin
         y_rnd = DataMin;
      end else begin
         y_rnd = DataMax;
      end
   end

   always_comb begin
      xin_in  = xin_ff;
      clip_in = clip_ff;
      priority if (cmd.sample_load) begin
         xin_in  = sample_in;
         clip_in = 1'b0;
      end else if (cmd.round) begin
         xin_in  = y_rnd;
         clip_in = clip_ff | ~rnd_ok;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         hist_vld_ff <= '0;
         s1_mac_ff   <= 1'b0;
         s1_cap_ff   <= 1'b0;
         s2_mac_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         coef_vld_ff <= coef_vld_in;
         hist_vld_ff <= hist_vld_in;
         s1_mac_ff   <= cmd.mac_en;
         s1_cap_ff   <= cmd.hist_cap;
         s2_mac_ff   <= s1_mac_ff;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_en) begin
         coef_rdv_ff <= coef_vld_ff[coef_addr];
         s1_tap_ff   <= cmd.tap;
      end
      if (cmd.hist_rd) begin
         hist_rdv_ff <= hist_vld_ff[hist_raddr];
      end
      if (s1_cap_ff) begin
         x1_ff <= hist_op;
      end
      s2_first_ff <= (s1_tap_ff == TAP_B0);
      s2_neg_ff   <= (s1_tap_ff == TAP_A1) || (s1_tap_ff == TAP_A2);
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      xin_ff      <= xin_in;
      clip_ff     <= clip_in;
      if (cmd.out_load) begin
         out_sample_ff <= xin_ff;
         out_sat_ff    <= clip_ff;
      end
   end

   assign out_busy   = out_vld_ff & ~rsp_tready;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_sat    = out_sat_ff;

endmodule

// File: hdl/bqf_ctrl.sv
// ----------------------------------------------------------------------------
// bqf_ctrl
// Controller: takes requests, sequences the five products of every section
// through the shared multiply-accumulate unit, updates the history and hands
// the finished sample to the output register.
// ----------------------------------------------------------------------------
module bqf_ctrl #(
   parameter int SECTIONS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  bqf_pkg::op_type                     req_op,
   input  logic [bqf_pkg::SecIdxW-1:0]         req_section,
   input  logic [bqf_pkg::SelW-1:0]            req_select,
   input  logic                                out_busy,
   output bqf_pkg::dp_cmd_type                 cmd,
   output logic [$clog2(5*SECTIONS)-1:0]       coef_addr,
   output logic [$clog2(2*SECTIONS+2)-1:0]     hist_raddr,
   output logic [$clog2(2*SECTIONS+2)-1:0]     hist_waddr
);

   import bqf_pkg::*;

   localparam int CoefAW  = $clog2(5 * SECTIONS);
   localparam int HistAW  = $clog2(2 * SECTIONS + 2);
   localparam int WaddrW  = SecIdxW + SelW + 1;
   localparam logic [HistAW-1:0] LastBase = HistAW'(2 * (SECTIONS - 1));

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_MUL,
      ST_ACC,
      ST_ROUND,
      ST_TAIL_RD,
      ST_TAIL_W0,
      ST_TAIL_W1,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   tap_type            tap_ff, tap_in;
   logic [CoefAW-1:0]  coef_addr_ff, coef_addr_in;
   logic [HistAW-1:0]  hist_base_ff, hist_base_in;
   logic [HistAW-1:0]  tap_offset;
   logic [WaddrW-1:0]  coef_waddr;
   logic               accept;
   logic               wr_ok;

   assign accept = req_tvalid & req_tready;
   assign wr_ok  = ({{(32-SecIdxW){1'b0}}, req_section} < SECTIONS)
                   && (req_select <= TAP_A2);
   // section * 5 + select
   assign coef_waddr = ({{(SelW-1){1'b0}}, req_section, 2'b00}
                        + {{(SelW+1){1'b0}}, req_section})
                       + {{(SecIdxW+1){1'b0}}, req_select};

   always_comb begin
      unique case (tap_ff)
         TAP_B1:  tap_offset = HistAW'(0);
         TAP_B2:  tap_offset = HistAW'(1);
         TAP_A1:  tap_offset = HistAW'(2);
         TAP_A2:  tap_offset = HistAW'(3);
         default: tap_offset = HistAW'(0);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      coef_addr_in = coef_addr_ff;
      hist_base_in = hist_base_ff;
      cmd          = '0;
      cmd.tap      = tap_ff;
      req_tready   = 1'b0;
      coef_addr    = coef_addr_ff;
      hist_raddr   = hist_base_ff + tap_offset;
      hist_waddr   = hist_base_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            coef_addr  = CoefAW'(coef_waddr);
            if (accept) begin
               if (req_op == OP_COEF) begin
                  cmd.coef_we = wr_ok;
               end else begin
                  cmd.sample_load = 1'b1;
                  tap_in          = TAP_B0;
                  coef_addr_in    = '0;
                  hist_base_in    = '0;
                  state_in        = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            cmd.mac_en   = 1'b1;
            cmd.hist_rd  = (tap_ff != TAP_B0);
            cmd.hist_cap = (tap_ff == TAP_B1);
            coef_addr_in = coef_addr_ff + CoefAW'(1);
            unique case (tap_ff)
               TAP_B0:  tap_in = TAP_B1;
               TAP_B1:  tap_in = TAP_B2;
               TAP_B2:  tap_in = TAP_A1;
               TAP_A1:  tap_in = TAP_A2;
               default: state_in = ST_MUL;
            endcase
         end
         ST_MUL: begin
            // x1 <= x0 happens next; here x0 <= section input
            cmd.hist_we = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.hist_we    = 1'b1;
            cmd.hist_wr_x1 = 1'b1;
            hist_waddr     = hist_base_ff + HistAW'(1);
            state_in       = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round    = 1'b1;
            hist_base_in = hist_base_ff + HistAW'(2);
            tap_in       = TAP_B0;
            state_in     = (hist_base_ff == LastBase) ? ST_TAIL_RD : ST_ISSUE;
         end
         ST_TAIL_RD: begin
            // shift the final output into the last history pair
            cmd.hist_rd  = 1'b1;
            cmd.hist_cap = 1'b1;
            hist_raddr   = hist_base_ff;
            state_in     = ST_TAIL_W0;
         end
         ST_TAIL_W0: begin
            cmd.hist_we = 1'b1;
            state_in    = ST_TAIL_W1;
         end
         ST_TAIL_W1: begin
            cmd.hist_we    = 1'b1;
            cmd.hist_wr_x1 = 1'b1;
            hist_waddr     = hist_base_ff + HistAW'(1);
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= TAP_B0;
         coef_addr_ff <= '0;
         hist_base_ff <= '0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         coef_addr_ff <= coef_addr_in;
         hist_base_ff <= hist_base_in;
      end
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the cascaded biquad IIR filter. Coefficient loads and samples
// are driven as stream requests. A scoreboard runs a fixed-point copy of the
// four-section cascade, queues the expected output sample and saturation flag
// of every filtered sample, and compares the responses against it in order.
// ----------------------------------------------------------------------------
module tb;
   import bqf_pkg::*;

   localparam int     Sections   = 4;
   localparam int     HistDepth  = 2 * Sections + 2;
   localparam int     RandItems  = 1800;
   localparam longint ClipLimit  = longint'(1) << (DataW - 1 + FracShift);
   localparam int     StallCycles = 600;

   typedef struct {
      logic signed [DataW-1:0] sample;
      logic                    saturated;
   } filter_result_type;

   // Keeps the coefficient bank and history of the cascade, predicts each
   // filtered sample and checks the responses in order.
   class cascade_scoreboard;
      logic signed [CoefW-1:0] coef_bank [Sections][TapsPerSection];
      logic signed [DataW-1:0] history [HistDepth];
      filter_result_type       expected_outputs [$];
      int                      fail_count;
      int                      responses_seen;

      function new();
         foreach (coef_bank[s, t]) coef_bank[s][t] = (t == TAP_B0) ? CoefOne : '0;
         foreach (history[i]) history[i] = '0;
         fail_count     = 0;
         responses_seen = 0;
      endfunction

      function filter_result_type filter_sample(logic signed [DataW-1:0] x);
         filter_result_type       res;
         logic signed [DataW-1:0] xin;
         longint                  acc;
         longint                  rnd;
         res.sample    = x;
         res.saturated = 1'b0;
         for (int s = 0; s < Sections; s++) begin
            xin = res.sample;
            acc = longint'(coef_bank[s][TAP_B0]) * longint'(xin)
                + longint'(coef_bank[s][TAP_B1]) * longint'(history[2*s])
                + longint'(coef_bank[s][TAP_B2]) * longint'(history[2*s+1])
                - longint'(coef_bank[s][TAP_A1]) * longint'(history[2*s+2])
                - longint'(coef_bank[s][TAP_A2]) * longint'(history[2*s+3]);
            rnd = acc + (longint'(1) << (FracShift - 1));
            if (rnd >= ClipLimit) begin
               res.sample    = DataMax;
               res.saturated = 1'b1;
            end else if (rnd < -ClipLimit) begin
               res.sample    = DataMin;
               res.saturated = 1'b1;
            end else begin
               res.sample = DataW'(rnd >>> FracShift);
            end
            history[2*s+1] = history[2*s];
            history[2*s]   = xin;
         end
         history[2*Sections+1] = history[2*Sections];
         history[2*Sections]   = res.sample;
         return res;
      endfunction

      function void note_request(logic op, logic [55:0] data);
         logic [SecIdxW-1:0] sec;
         logic [SelW-1:0]    sel;
         sec = data[25:24];
         sel = data[28:26];
         if (op == OP_COEF) begin
            // drop loads to a missing section or an unused selector
            if (sec < Sections && sel <= TAP_A2) coef_bank[sec][sel] = data[54:29];
         end else begin
            expected_outputs.push_back(filter_sample(data[23:0]));
         end
      endfunction

      function void check_response(logic [DataW-1:0] sample, logic saturated);
         filter_result_type exp_res;
         responses_seen++;
         if (expected_outputs.size() == 0) begin
            $display("%0t unexpected response: sample_out %0d saturated %0b",
                     $time, $signed(sample), saturated);
            fail_count++;
            return;
         end
         exp_res = expected_outputs.pop_front();
         if (sample !== exp_res.sample) begin
            $display("%0t sample_out mismatch: expected %0d actual %0d",
                     $time, exp_res.sample, $signed(sample));
            fail_count++;
         end
         if (saturated !== exp_res.saturated) begin
            $display("%0t saturated mismatch: expected %0b actual %0b",
                     $time, exp_res.saturated, saturated);
            fail_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // sample_in[23:0], section_index[25:24], coef_select[28:26],
   // coef_value[54:29], zero[55]
   logic [55:0] req_tdata = '0;
   // operation[0]
   logic [0:0]  req_tuser = OP_FILTER;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // sample_out[23:0]
   logic [23:0] rsp_tdata;
   // saturated[0]
   logic [0:0]  rsp_tuser;

   cascade_scoreboard sb;
   int                items_sent = 0;
   int                burst_left = 0;

   cascaded_biquad_iir_filter #(
      .SECTIONS(Sections)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser[0]);
      end
   end

   // Keep valid high; lowering happens in idle_sender and when the main sequence pauses or ends.
   task automatic send_request(input logic op, input logic [55:0] data);
      req_tuser  <= op;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_sample(input logic signed [DataW-1:0] x);
      send_request(OP_FILTER, {1'b0, CoefW'($urandom()), SelW'($urandom()),
                               SecIdxW'($urandom()), x});
   endtask

   task automatic send_coef(input int sec, input int sel, input logic [CoefW-1:0] value);
      send_request(OP_COEF, {1'b0, value, SelW'(sel), SecIdxW'(sec), DataW'($urandom())});
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         idle_sender(($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // Load all five taps of every section: a stable design, or raw noise.
   task automatic load_bank(input bit wild);
      int b;
      int a1;
      int a2;
      int lim;
      for (int s = 0; s < Sections; s++) begin
         a2  = int'($urandom_range(0, 2 * 3774873)) - 3774873;
         lim = (4194304 + a2) * 19 / 20;
         a1  = int'($urandom_range(0, 2 * lim)) - lim;
         for (int t = int'(TAP_B0); t <= int'(TAP_A2); t++) begin
            b = int'($urandom_range(0, 4194304)) - 2097152;
            pace_sender();
            if (wild) send_coef(s, t, CoefW'($urandom()));
            else if (t == int'(TAP_A1)) send_coef(s, t, CoefW'(a1));
            else if (t == int'(TAP_A2)) send_coef(s, t, CoefW'(a2));
            else send_coef(s, t, CoefW'(b));
         end
      end
   endtask

   // Receiver: stall on a changing pattern; once, hold off long enough that
   // the block backs up and stalls its input.
   initial begin
      int mode;
      int span;
      bit held;
      held = 1'b0;
      wait (!reset);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(20, 200);
         repeat (span) begin
            if (!held && sb.responses_seen >= 200) begin
               rsp_tready <= 1'b0;
               repeat (StallCycles) @(posedge clock);
               held = 1'b1;
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int  pick;
      int  sel;
      bit  paused;
      logic signed [DataW-1:0] x;
      sb     = new();
      paused = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pass-through at the sample extremes
      send_sample('0);
      send_sample(DataMax);
      send_sample(DataMin);
      send_sample(-1);
      // unused selectors must leave the bank alone
      for (int k = int'(TAP_A2) + 1; k < (1 << SelW); k++)
         send_coef(k % Sections, k, CoefW'($urandom()));
      // largest gain in the first section: clip both ways
      send_coef(0, TAP_B0, {1'b0, {(CoefW-1){1'b1}}});
      send_sample(DataMax);
      send_sample(DataMin);
      send_sample(1);
      // half gain: exact halves round toward plus infinity
      send_coef(0, TAP_B0, CoefW'(2097152));
      send_sample(1);
      send_sample(-1);
      send_sample(3);
      send_sample(-3);
      // coefficient extremes on the b1 and b2 taps of section 2 and the a1 and a2 taps of section 3
      send_coef(2, TAP_B1, {1'b1, {(CoefW-1){1'b0}}});
      send_coef(2, TAP_B2, {1'b0, {(CoefW-1){1'b1}}});
      send_coef(3, TAP_A1, {1'b1, {(CoefW-1){1'b0}}});
      send_coef(3, TAP_A2, {1'b0, {(CoefW-1){1'b1}}});
      send_sample(DataMax);

      load_bank(1'b0);
      items_sent = 0;
      while (items_sent < RandItems) begin
         if (!paused && items_sent >= RandItems / 2) begin
            // let the pipeline drain completely before going on
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.expected_outputs.size() > 0) @(posedge clock);
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            load_bank($urandom_range(0, 9) == 0);
         end else if (pick < 13) begin
            sel = $urandom_range(0, (1 << SelW) - 1);
            pace_sender();
            send_coef($urandom_range(0, Sections - 1), sel, CoefW'($urandom()));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) x = DataW'($urandom());
            else if (pick < 85) x = DataW'(int'($urandom_range(0, 131072)) - 65536);
            else begin
               case ($urandom_range(0, 3))
                  0: x = DataMax;
                  1: x = DataMin;
                  2: x = '0;
                  default: x = -1;
               endcase
            end
            pace_sender();
            send_sample(x);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_outputs.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
